>>> rtl/core/escape_sequence_unescaper_core_macros.svh
// Assertion helpers shared by the core modules.
`ifndef ESCAPE_SEQUENCE_UNESCAPER_CORE_MACROS_SVH
`define ESCAPE_SEQUENCE_UNESCAPER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ESCU_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ESCU_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/escu_pkg.sv
package escu_pkg;

	// Characters the decoder recognizes
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_UPPER_X   = 8'h58;
	localparam logic [7:0] CH_LOWER_X   = 8'h78;
	localparam logic [7:0] CH_LOWER_B   = 8'h62;
	localparam logic [7:0] CH_LOWER_T   = 8'h74;
	localparam logic [7:0] CH_LOWER_N   = 8'h6E;
	localparam logic [7:0] CH_LOWER_F   = 8'h66;
	localparam logic [7:0] CH_LOWER_R   = 8'h72;
	localparam logic [7:0] CH_DIGIT_0   = 8'h30;
	localparam logic [7:0] CH_DIGIT_9   = 8'h39;
	localparam logic [7:0] CH_UPPER_A   = 8'h41;
	localparam logic [7:0] CH_UPPER_F   = 8'h46;
	localparam logic [7:0] CH_LOWER_A   = 8'h61;

	// Control bytes produced by the short escapes
	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_HT = 8'h09;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_CR = 8'h0D;

	// Expanded form is backslash, X, four digits
	localparam logic [2:0] EXPAND_LEN = 3'd6;

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESC    = 4'b0010,
		MODE_HEX    = 4'b0100,
		MODE_DROP   = 4'b1000
	} mode_t;

	// One queued command: an optional code point, an optional plain byte
	// after it, or a lone error result.
	typedef struct packed {
		logic        error;
		logic        last;
		logic        has_value;
		logic [15:0] value;
		logic        has_byte;
		logic [7:0]  data;
	} cmd_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] digit;
	} hex_t;

	function automatic hex_t hex_val(input logic [7:0] b);
		hex_t r;
		r = '0;
		if (b inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
			r.valid = 1'b1;
			r.digit = 4'(b - CH_DIGIT_0);
		end else if (b inside {[CH_UPPER_A:CH_UPPER_F]}) begin
			r.valid = 1'b1;
			r.digit = 4'(b - CH_UPPER_A + 8'd10);
		end else if (b inside {[CH_LOWER_A:CH_LOWER_F]}) begin
			r.valid = 1'b1;
			r.digit = 4'(b - CH_LOWER_A + 8'd10);
		end
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = CH_DIGIT_0 + 8'(d);
		end else begin
			r = CH_UPPER_A + 8'(d) - 8'd10;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/escu_in_if.sv
interface escu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_string;

	modport source (output valid, output in_byte, output end_of_string, input ready);
	modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

>>> rtl/core/escu_out_if.sv
interface escu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       error;
	logic       last;

	modport source (output valid, output out_byte, output error, output last, input ready);
	modport sink (input valid, input out_byte, input error, input last, output ready);
endinterface

>>> rtl/core/escu_front.sv
`include "escape_sequence_unescaper_core_macros.svh"

module escu_front #(
	parameter int MAX_HEX_DIGITS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	escu_in_if.sink          din,
	input  logic             full,
	output logic             push,
	output escu_pkg::cmd_t   cmd
);

	escu_pkg::mode_t mode_q, mode_d;
	logic [2:0]      dc_q, dc_d, dc_inc;
	logic [15:0]     cv_q, cv_d, cv_next;
	escu_pkg::hex_t  hx;
	logic            accept;
	logic            as_normal;
	logic            fail;
	logic [7:0]      b;
	logic            eos;

	assign din.ready = !full;
	assign accept    = din.valid && din.ready;
	assign b         = din.in_byte;
	assign eos       = din.end_of_string;

	always_comb begin
		mode_d    = mode_q;
		dc_d      = dc_q;
		cv_d      = cv_q;
		cmd       = '0;
		as_normal = 1'b0;
		fail      = 1'b0;
		hx        = escu_pkg::hex_val(b);
		dc_inc    = dc_q + 3'd1;
		cv_next   = {cv_q[11:0], hx.digit};

		case (mode_q)
			escu_pkg::MODE_NORMAL: begin
				as_normal = 1'b1;
			end
			escu_pkg::MODE_ESC: begin
				mode_d       = escu_pkg::MODE_NORMAL;
				cmd.has_byte = 1'b1;
				case (b)
					escu_pkg::CH_LOWER_B: cmd.data = escu_pkg::CTL_BS;
					escu_pkg::CH_LOWER_T: cmd.data = escu_pkg::CTL_HT;
					escu_pkg::CH_LOWER_N: cmd.data = escu_pkg::CTL_LF;
					escu_pkg::CH_LOWER_F: cmd.data = escu_pkg::CTL_FF;
					escu_pkg::CH_LOWER_R: cmd.data = escu_pkg::CTL_CR;
					escu_pkg::CH_UPPER_X, escu_pkg::CH_LOWER_X: begin
						cmd.has_byte = 1'b0;
						if (eos) begin
							fail = 1'b1;
						end else begin
							mode_d = escu_pkg::MODE_HEX;
							dc_d   = '0;
							cv_d   = '0;
						end
					end
					default: cmd.data = b;
				endcase
			end
			escu_pkg::MODE_HEX: begin
				if (hx.valid) begin
					if (dc_inc >= 3'(MAX_HEX_DIGITS) || eos) begin
						cmd.has_value = 1'b1;
						cmd.value     = cv_next;
						mode_d        = escu_pkg::MODE_NORMAL;
						dc_d          = '0;
						cv_d          = '0;
					end else begin
						dc_d = dc_inc;
						cv_d = cv_next;
					end
				end else if (dc_q == 3'd0) begin
					fail = 1'b1;
				end else begin
					// flush the collected value, then treat this byte as plain input
					cmd.has_value = 1'b1;
					cmd.value     = cv_q;
					mode_d        = escu_pkg::MODE_NORMAL;
					dc_d          = '0;
					cv_d          = '0;
					as_normal     = 1'b1;
				end
			end
			escu_pkg::MODE_DROP: begin
				if (eos) begin
					mode_d = escu_pkg::MODE_NORMAL;
				end
			end
			default: begin
				mode_d = escu_pkg::MODE_NORMAL;
			end
		endcase

		if (as_normal) begin
			if (b == escu_pkg::CH_BACKSLASH) begin
				if (eos) begin
					fail = 1'b1;
				end else begin
					mode_d = escu_pkg::MODE_ESC;
				end
			end else begin
				cmd.has_byte = 1'b1;
				cmd.data     = b;
			end
		end

		cmd.last = eos;

		// an error wipes whatever else this byte produced
		if (fail) begin
			cmd       = '0;
			cmd.error = 1'b1;
			cmd.last  = 1'b1;
			mode_d    = eos ? escu_pkg::MODE_NORMAL : escu_pkg::MODE_DROP;
			dc_d      = '0;
			cv_d      = '0;
		end
	end

	assign push = accept && (cmd.error || cmd.has_value || cmd.has_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= escu_pkg::MODE_NORMAL;
			dc_q   <= '0;
			cv_q   <= '0;
		end else if (accept) begin
			mode_q <= mode_d;
			dc_q   <= dc_d;
			cv_q   <= cv_d;
		end
	end

	`ESCU_IMPLIES(a_digits_only_in_hex, clk, arst_n, mode_q != escu_pkg::MODE_HEX, (dc_q == 3'd0) && (cv_q == 16'd0), "digit state left over outside hex mode")
	`ESCU_IMPLIES(a_digit_run_bounded, clk, arst_n, mode_q == escu_pkg::MODE_HEX, dc_q < 3'(MAX_HEX_DIGITS), "digit run not flushed at limit")

endmodule

>>> rtl/core/escu_queue.sv
module escu_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  escu_pkg::cmd_t cmd_in,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output escu_pkg::cmd_t cmd_out
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	escu_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign cmd_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/core/escu_back.sv
`include "escape_sequence_unescaper_core_macros.svh"

module escu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  escu_pkg::cmd_t cmd,
	output logic           pop,
	escu_out_if.source     dout
);

	logic [2:0] idx_q;
	logic [2:0] n_val, total, last_idx;
	logic       big;
	logic       advance;
	logic       at_end;
	logic [7:0] res_byte;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_err_q;
	logic       out_last_q;

	assign big      = (cmd.value[15:7] != '0);
	assign n_val    = cmd.has_value ? (big ? escu_pkg::EXPAND_LEN : 3'd1) : 3'd0;
	assign total    = n_val + {2'b00, cmd.has_byte};
	assign last_idx = cmd.error ? 3'd0 : total - 3'd1;
	assign at_end   = (idx_q == last_idx);
	assign advance  = cmd_valid && (!out_valid_q || dout.ready);
	assign pop      = advance && at_end;

	always_comb begin
		res_byte = cmd.data;
		if (cmd.error) begin
			res_byte = '0;
		end else if (idx_q < n_val) begin
			if (big) begin
				case (idx_q)
					3'd0:    res_byte = escu_pkg::CH_BACKSLASH;
					3'd1:    res_byte = escu_pkg::CH_UPPER_X;
					3'd2:    res_byte = escu_pkg::hex_char(cmd.value[15:12]);
					3'd3:    res_byte = escu_pkg::hex_char(cmd.value[11:8]);
					3'd4:    res_byte = escu_pkg::hex_char(cmd.value[7:4]);
					default: res_byte = escu_pkg::hex_char(cmd.value[3:0]);
				endcase
			end else begin
				res_byte = cmd.value[7:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				idx_q       <= at_end ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= res_byte;
			out_err_q  <= cmd.error;
			out_last_q <= at_end && cmd.last;
		end
	end

	assign dout.valid    = out_valid_q;
	assign dout.out_byte = out_byte_q;
	assign dout.error    = out_err_q;
	assign dout.last     = out_last_q;

	`ESCU_IMPLIES(a_mid_cmd_has_head, clk, arst_n, idx_q != 3'd0, cmd_valid, "expansion in progress with empty queue")
	`ESCU_IMPLIES(a_error_single, clk, arst_n, cmd_valid && cmd.error, idx_q == 3'd0, "error command expanded past one result")
	`ESCU_NEXT(a_pop_rewinds, clk, arst_n, pop, idx_q == 3'd0, "result index not rewound after pop")

endmodule

>>> rtl/core/escape_sequence_unescaper_core.sv
// Channel | Dir | Payload                   | Handshake
// din     | in  | in_byte, end_of_string    | valid/ready, transfer when both high
// dout    | out | out_byte, error, last     | valid/ready, transfer when both high
//
// A plain byte or a short escape moves one transfer per cycle, end to end, while
// dout is ready. A hex code of 0x80 or more expands into six output transfers
// (seven with the byte that closed the digit run), which the back end emits one
// per cycle unless stalled. The front keeps taking bytes during an expansion
// until the command queue (QUEUE_DEPTH entries) is full. Output is registered.
// arst_n clears the decode state, the queue pointers and the output valid.
module escape_sequence_unescaper_core #(
	parameter int MAX_HEX_DIGITS = 4,
	parameter int QUEUE_DEPTH    = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	escu_in_if.sink    din,
	escu_out_if.source dout
);

	// Front to queue
	logic           push;
	escu_pkg::cmd_t cmd_push;
	logic           full;

	// Queue to back
	logic           pop;
	logic           head_valid;
	escu_pkg::cmd_t cmd_head;

	// Front: tracks normal / escape / hex / drop mode per byte and turns each
	// byte into at most one command (value, trailing byte, or error).
	escu_front #(
		.MAX_HEX_DIGITS(MAX_HEX_DIGITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.full   (full),
		.push   (push),
		.cmd    (cmd_push)
	);

	// Short queue lets the front keep decoding while a hex expansion drains.
	escu_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd_push),
		.full    (full),
		.pop     (pop),
		.valid   (head_valid),
		.cmd_out (cmd_head)
	);

	// Back: walks each command into the output register one result per cycle while dout is ready.
	escu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (cmd_head),
		.pop       (pop),
		.dout      (dout)
	);

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	// Must match the digit limit the block is built with.
	localparam int MAX_DIGITS = 4;
	// Codes of 0x80 and up leave the block in long form.
	localparam logic [15:0] SHORT_FORM_LIMIT = 16'h0080;
	// Quote characters that the short escapes pass through unchanged.
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	localparam int ITEM_TARGET = 480;
	localparam int MAX_WAIT = 19;
	// Receiver hold-off, long enough to back the command queue up to the input.
	localparam int LONG_HOLD = 300;
	// Drain tail for the registered output, plus margin.
	localparam int TAIL_CYCLES = 20;
	// Worst case is about 500 transfers, each with a full input gap and up to 7 fully stalled results, plus holds.
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       error;
		logic       last;
	} unesc_out_t;

	// Tracks the decode state the block should be in and the output transfers
	// still owed to the receiver.
	class unescape_scoreboard;
		escu_pkg::mode_t esc_mode = escu_pkg::MODE_NORMAL;
		logic [2:0] digit_cnt = '0;
		logic [15:0] hex_value = '0;
		unesc_out_t owed_bytes[$];
		unesc_out_t step_bytes[$];
		int         mismatches = 0;

		static function logic [7:0] hex_glyph(logic [3:0] d);
			if (d < 4'd10) begin
				return escu_pkg::CH_DIGIT_0 + 8'(d);
			end
			return escu_pkg::CH_UPPER_A + 8'(d) - 8'd10;
		endfunction

		local function int digit_of(logic [7:0] ch);
			if (ch >= escu_pkg::CH_DIGIT_0 && ch <= escu_pkg::CH_DIGIT_9) begin
				return int'(ch - escu_pkg::CH_DIGIT_0);
			end
			if (ch >= escu_pkg::CH_UPPER_A && ch <= escu_pkg::CH_UPPER_F) begin
				return int'(ch - escu_pkg::CH_UPPER_A) + 10;
			end
			if (ch >= escu_pkg::CH_LOWER_A && ch <= escu_pkg::CH_LOWER_A + 8'd5) begin
				return int'(ch - escu_pkg::CH_LOWER_A) + 10;
			end
			return -1;
		endfunction

		local function void emit(logic [7:0] ch);
			step_bytes.push_back('{out_byte: ch, error: 1'b0, last: 1'b0});
		endfunction

		local function void emit_code(logic [15:0] v);
			if (v < SHORT_FORM_LIMIT) begin
				emit(v[7:0]);
			end else begin
				emit(escu_pkg::CH_BACKSLASH);
				emit(escu_pkg::CH_UPPER_X);
				emit(hex_glyph(v[15:12]));
				emit(hex_glyph(v[11:8]));
				emit(hex_glyph(v[7:4]));
				emit(hex_glyph(v[3:0]));
			end
			digit_cnt = '0;
			hex_value = '0;
		endfunction

		// A bad escape throws away anything formed this step; the rest of the
		// string is swallowed unless this byte already ended it.
		local function void flag_error(logic eos);
			step_bytes.delete();
			step_bytes.push_back('{out_byte: 8'h00, error: 1'b1, last: 1'b1});
			esc_mode = eos ? escu_pkg::MODE_NORMAL : escu_pkg::MODE_DROP;
			digit_cnt = '0;
			hex_value = '0;
		endfunction

		function void note_input(logic [7:0] ch, logic eos);
			bit plain;
			int d;
			plain = 1'b0;
			step_bytes.delete();
			case (esc_mode)
				escu_pkg::MODE_NORMAL: begin
					plain = 1'b1;
				end
				escu_pkg::MODE_ESC: begin
					esc_mode = escu_pkg::MODE_NORMAL;
					case (ch)
						escu_pkg::CH_LOWER_B: emit(escu_pkg::CTL_BS);
						escu_pkg::CH_LOWER_T: emit(escu_pkg::CTL_HT);
						escu_pkg::CH_LOWER_N: emit(escu_pkg::CTL_LF);
						escu_pkg::CH_LOWER_F: emit(escu_pkg::CTL_FF);
						escu_pkg::CH_LOWER_R: emit(escu_pkg::CTL_CR);
						escu_pkg::CH_UPPER_X, escu_pkg::CH_LOWER_X: begin
							if (eos) begin
								flag_error(eos);
							end else begin
								esc_mode = escu_pkg::MODE_HEX;
								digit_cnt = '0;
								hex_value = '0;
							end
						end
						default: emit(ch);
					endcase
				end
				escu_pkg::MODE_HEX: begin
					d = digit_of(ch);
					if (d >= 0) begin
						hex_value = {hex_value[11:0], 4'(d)};
						digit_cnt = digit_cnt + 3'd1;
						if (int'(digit_cnt) >= MAX_DIGITS || eos) begin
							emit_code(hex_value);
							esc_mode = escu_pkg::MODE_NORMAL;
						end
					end else if (digit_cnt == '0) begin
						flag_error(eos);
					end else begin
						// run closed by a non-digit: flush, then treat the byte as plain
						emit_code(hex_value);
						esc_mode = escu_pkg::MODE_NORMAL;
						plain = 1'b1;
					end
				end
				escu_pkg::MODE_DROP: begin
					if (eos) begin
						esc_mode = escu_pkg::MODE_NORMAL;
					end
				end
				default: begin
					esc_mode = escu_pkg::MODE_NORMAL;
				end
			endcase
			if (plain) begin
				if (ch != escu_pkg::CH_BACKSLASH) begin
					emit(ch);
				end else if (eos) begin
					flag_error(eos);
				end else begin
					esc_mode = escu_pkg::MODE_ESC;
				end
			end
			if (step_bytes.size() > 0 && eos) begin
				step_bytes[$].last = 1'b1;
			end
			foreach (step_bytes[i]) begin
				owed_bytes.push_back(step_bytes[i]);
			end
		endfunction

		function void check_output(logic [7:0] out_byte, logic error, logic last);
			unesc_out_t exp_out;
			if (owed_bytes.size() == 0) begin
				$error("unexpected transfer: out_byte=%h error=%b last=%b", out_byte, error, last);
				mismatches++;
				return;
			end
			exp_out = owed_bytes.pop_front();
			if (out_byte !== exp_out.out_byte) begin
				$error("out_byte: expected %h, got %h", exp_out.out_byte, out_byte);
				mismatches++;
			end
			if (error !== exp_out.error) begin
				$error("error: expected %b, got %b", exp_out.error, error);
				mismatches++;
			end
			if (last !== exp_out.last) begin
				$error("last: expected %b, got %b", exp_out.last, last);
				mismatches++;
			end
		endfunction

		function int pending();
			return owed_bytes.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	escu_in_if din_bus();
	escu_out_if dout_bus();

	escape_sequence_unescaper_core #(
		.MAX_HEX_DIGITS(MAX_DIGITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_bus),
		.dout(dout_bus)
	);

	unescape_scoreboard sb;

	int items_sent = 0;
	int cycles = 0;
	// Long receiver hold-offs: requested by the stimulus, served by the receiver.
	int holds_asked = 0;
	int holds_done = 0;
	// Calm stretches: no idle cycles on that side.
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog; a hang anywhere ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offer one byte after a drawn gap and hold it until the transfer.
	// valid stays high afterward so back-to-back bytes need no second write.
	task automatic send_item(input logic [7:0] ch, input logic eos);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			din_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_bus.valid <= 1'b1;
		din_bus.in_byte <= ch;
		din_bus.end_of_string <= eos;
		do @(posedge clk); while (din_bus.ready !== 1'b1);
		sb.note_input(ch, eos);
		items_sent++;
	endtask

	// Stop offering and let every owed result come out.
	task automatic wait_for_drain();
		din_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Directed strings: field extremes, a zero byte, a short escape, a hex run
	// closed by a plain byte (seven results), a run cut by the string end, a full
	// run, hex with no digits followed by dropped bytes, and both error endings.
	task automatic run_directed();
		logic [8:0] seq[$];
		seq = '{
			{8'h01, 1'b0}, {8'hFF, 1'b0}, {8'h00, 1'b1},
			{escu_pkg::CH_BACKSLASH, 1'b0}, {escu_pkg::CH_LOWER_N, 1'b0},
			{escu_pkg::CH_BACKSLASH, 1'b0}, {escu_pkg::CH_LOWER_X, 1'b0},
			{escu_pkg::CH_LOWER_F, 1'b0},
			{escu_pkg::CH_UPPER_F, 1'b0}, {escu_pkg::CH_LOWER_N, 1'b0},
			{escu_pkg::CH_BACKSLASH, 1'b0}, {escu_pkg::CH_UPPER_X, 1'b0},
			{escu_pkg::CH_DIGIT_0 + 8'd4, 1'b0},
			{escu_pkg::CH_DIGIT_0 + 8'd1, 1'b1},
			{escu_pkg::CH_BACKSLASH, 1'b0}, {escu_pkg::CH_LOWER_X, 1'b0},
			{escu_pkg::CH_DIGIT_0 + 8'd8, 1'b0},
			{escu_pkg::CH_DIGIT_0, 1'b0}, {escu_pkg::CH_DIGIT_0, 1'b0},
			{escu_pkg::CH_DIGIT_0, 1'b1},
			{escu_pkg::CH_BACKSLASH, 1'b0}, {escu_pkg::CH_LOWER_X, 1'b0},
			{escu_pkg::CH_LOWER_R, 1'b0},
			{escu_pkg::CH_LOWER_T, 1'b1},
			{escu_pkg::CH_BACKSLASH, 1'b0}, {escu_pkg::CH_UPPER_X, 1'b1},
			{escu_pkg::CH_BACKSLASH, 1'b1}
		};
		foreach (seq[i]) begin
			send_item(seq[i][8:1], seq[i][0]);
		end
	endtask

	// One random string: mostly well-formed escapes with random content,
	// some raw bytes and lone backslashes as noise. Hex runs get 0..5 digits
	// so empty, short, full and overlong runs all show up.
	task automatic send_random_string();
		logic [7:0] body[$];
		logic [7:0] short_esc[9];
		logic [3:0] d;
		int pieces;
		int kind;
		int n;
		short_esc = '{escu_pkg::CH_LOWER_B, escu_pkg::CH_LOWER_T, escu_pkg::CH_LOWER_N,
			escu_pkg::CH_LOWER_F, escu_pkg::CH_LOWER_R,
			CH_DQUOTE, CH_SQUOTE, escu_pkg::CH_BACKSLASH, 8'h00};
		pieces = $urandom_range(1, 6);
		repeat (pieces) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				body.push_back(8'($urandom_range(1, 255)));
			end else if (kind < 33) begin
				body.push_back(8'h00);
			end else if (kind < 55) begin
				body.push_back(escu_pkg::CH_BACKSLASH);
				n = $urandom_range(0, 9);
				body.push_back(n < 9 ? short_esc[n] : 8'($urandom_range(0, 255)));
			end else if (kind < 92) begin
				body.push_back(escu_pkg::CH_BACKSLASH);
				body.push_back($urandom_range(0, 1) ? escu_pkg::CH_UPPER_X
					: escu_pkg::CH_LOWER_X);
				n = $urandom_range(0, 5);
				repeat (n) begin
					d = 4'($urandom_range(0, 15));
					if (d >= 4'd10 && $urandom_range(0, 1)) begin
						body.push_back(escu_pkg::CH_LOWER_A + 8'(d) - 8'd10);
					end else begin
						body.push_back(unescape_scoreboard::hex_glyph(d));
					end
				end
			end else begin
				body.push_back(escu_pkg::CH_BACKSLASH);
			end
		end
		foreach (body[i]) begin
			send_item(body[i], i == body.size() - 1);
		end
	endtask

	// Receiver: draws a stall per transfer, serves long hold-offs on request,
	// and checks every output transfer against the scoreboard.
	initial begin : recv_side
		int stall;
		int taken;
		taken = 0;
		dout_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (holds_done < holds_asked) begin
				holds_done++;
				stall = LONG_HOLD;
			end else begin
				stall = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (stall > 0) begin
				dout_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dout_bus.ready <= 1'b1;
			do @(posedge clk); while (dout_bus.valid !== 1'b1);
			sb.check_output(dout_bus.out_byte, dout_bus.error, dout_bus.last);
			taken++;
			if (taken % 32 == 0) begin
				recv_calm = ($urandom_range(0, 3) == 0);
			end
		end
	end

	initial begin : send_side
		int strings;
		sb = new();
		arst_n = 1'b0;
		din_bus.valid = 1'b0;
		din_bus.in_byte = '0;
		din_bus.end_of_string = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		wait_for_drain();

		strings = 0;
		while (items_sent < ITEM_TARGET) begin
			// Receiver goes quiet while the sender keeps pushing with no gaps,
			// so the queue fills and the input stalls.
			if (strings == 12) begin
				holds_asked++;
			end
			// Sender stops until everything owed has come out.
			if (strings == 40) begin
				wait_for_drain();
			end
			send_calm = (strings >= 12 && strings < 20) || ($urandom_range(0, 4) == 0);
			send_random_string();
			strings++;
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
